// ----- hdl/complex_fixed_point_alu_macros.svh -----
// ---------------------------------------------------------------------------
// Complex fixed-point ALU assertion macros
// Shared concurrent assertion forms, clocked on clk, gated by rst_n.
// ---------------------------------------------------------------------------
`ifndef COMPLEX_FIXED_POINT_ALU_MACROS_SVH
`define COMPLEX_FIXED_POINT_ALU_MACROS_SVH

// same-cycle implication
`define CFPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CFPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/cfpa_pkg.sv -----
// ---------------------------------------------------------------------------
// cfpa_pkg
// Types, codes and width helpers of the complex fixed-point ALU.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfpa_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int FRACTION_BITS_DEF = 8;

  // quotient bits kept by the divider (bit 32 down to 0)
  localparam int QBITS = 33;

  localparam logic [32:0] LIM_POS_MAG = 33'h0_7FFF_FFFF;
  localparam logic [32:0] LIM_NEG_MAG = 33'h0_8000_0000;
  localparam logic [31:0] RES_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] RES_MIN     = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cfpa_op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_SAT = 2'd2
  } cfpa_status_t;

  typedef struct packed {
    logic is_div;
    logic dz;
  } cfpa_ctl_t;

  // signed width of a combined part before scaling/division
  function automatic int cfpa_sw(int w, int f);
    int a;
    int b;
    a = 2 * w + 2;
    b = w + f + 2;
    return (a > b) ? a : b;
  endfunction

  // working width of the divider remainder
  function automatic int cfpa_cw(int w, int f);
    int x;
    int d;
    x = cfpa_sw(w, f) + 2 * f;
    d = 2 * w + QBITS;
    return ((x > d) ? x : d) + 1;
  endfunction

endpackage

// ----- hdl/cfpa_div.sv -----
// ---------------------------------------------------------------------------
// cfpa_div
// Two-lane restoring divider pipeline, one quotient bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfpa_div #(
  parameter int  OPERAND_WIDTH = cfpa_pkg::OPERAND_WIDTH_DEF,
  parameter int  FRACTION_BITS = cfpa_pkg::FRACTION_BITS_DEF,
  localparam int SW = cfpa_pkg::cfpa_sw(OPERAND_WIDTH, FRACTION_BITS),
  localparam int CW = cfpa_pkg::cfpa_cw(OPERAND_WIDTH, FRACTION_BITS),
  localparam int DW = 2 * OPERAND_WIDTH,
  localparam int DS = cfpa_pkg::QBITS + 1
) (
  input  logic                  clk,
  input  logic [DS-1:0]         load,
  input  cfpa_pkg::cfpa_ctl_t   ctl_i,
  input  logic signed [SW-1:0]  num_i [2],
  input  logic [DW-1:0]         den_i,
  output cfpa_pkg::cfpa_ctl_t   ctl_o,
  output logic                  neg_o [2],
  output logic [CW-1:0]         mag_o [2],
  output logic                  ovf_o [2]
);
  import cfpa_pkg::*;

  logic [CW-1:0]    rem_r [2][DS];
  logic [QBITS-1:0] q_r   [2][DS];
  logic             neg_r [2][DS];
  logic             ovf_r [2][DS];
  logic [DW-1:0]    den_r [DS];
  cfpa_ctl_t        ctl_r [DS];

  // prep: sign/magnitude, scaled dividend, overflow check
  logic [SW-1:0] mag0   [2];
  logic [CW-1:0] x0     [2];
  logic          ovf0   [2];
  logic [CW-1:0] dtop0;

  always_comb begin
    dtop0 = CW'(den_i) << QBITS;
    for (int l = 0; l < 2; l++) begin
      mag0[l] = num_i[l][SW-1] ? SW'(0 - num_i[l]) : SW'(num_i[l]);
      x0[l]   = ctl_i.is_div ? (CW'(mag0[l]) << (2 * FRACTION_BITS)) : CW'(mag0[l]);
      ovf0[l] = ctl_i.is_div && !ctl_i.dz && (x0[l] >= dtop0);
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      den_r[0] <= den_i;
      ctl_r[0] <= ctl_i;
      for (int l = 0; l < 2; l++) begin
        rem_r[l][0] <= x0[l];
        q_r[l][0]   <= '0;
        neg_r[l][0] <= num_i[l][SW-1];
        ovf_r[l][0] <= ovf0[l];
      end
    end
  end

  for (genvar j = 1; j < DS; j++) begin : g_step
    localparam int QB = DS - 1 - j;
    logic [CW:0]      trial [2];
    logic             take  [2];
    logic [QBITS-1:0] q_nxt [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {1'b0, rem_r[l][j-1]} - {1'b0, (CW'(den_r[j-1]) << QB)};
        take[l]  = ctl_r[j-1].is_div && !ctl_r[j-1].dz && !ovf_r[l][j-1] && !trial[l][CW];
        q_nxt[l]     = q_r[l][j-1];
        q_nxt[l][QB] = take[l];
      end
    end

    always_ff @(posedge clk) begin
      if (load[j]) begin
        den_r[j] <= den_r[j-1];
        ctl_r[j] <= ctl_r[j-1];
        for (int l = 0; l < 2; l++) begin
          rem_r[l][j]     <= take[l] ? trial[l][CW-1:0] : rem_r[l][j-1];
          q_r[l][j]       <= q_nxt[l];
          neg_r[l][j]     <= neg_r[l][j-1];
          ovf_r[l][j]     <= ovf_r[l][j-1];
        end
      end
    end
  end

  always_comb begin
    ctl_o = ctl_r[DS-1];
    for (int l = 0; l < 2; l++) begin
      neg_o[l] = neg_r[l][DS-1];
      ovf_o[l] = ovf_r[l][DS-1];
      mag_o[l] = ctl_r[DS-1].is_div ? CW'(q_r[l][DS-1]) : rem_r[l][DS-1];
    end
  end

endmodule

// ----- hdl/complex_fixed_point_alu.sv -----
// ---------------------------------------------------------------------------
// complex_fixed_point_alu
// Pipelined complex add/subtract/multiply/divide, Q8.8 in, saturated Q16.16 out.
// ---------------------------------------------------------------------------
//  channel | dir | ports                       | payload
//  in      | in  | in_tvalid/tready/tdata/tuser | a_real, a_imag, b_real, b_imag; req_type
//  out     | out | out_tvalid/tready/tdata/tuser| res_real, res_imag; status
//
//  Every operation takes the same path; one transaction per cycle sustained while out_tready is high.
//  Depth set by the divider: one stage per quotient bit (33) plus prep.
//  rst_n (sync, active low) clears all stage valid bits; payload is not reset.
//  Each stage moves when the next one is empty or moving, so bubbles collapse
//  and an item is accepted while a result waits at the output if a stage is empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_fixed_point_alu #(
  parameter int  OPERAND_WIDTH = cfpa_pkg::OPERAND_WIDTH_DEF,
  parameter int  FRACTION_BITS = cfpa_pkg::FRACTION_BITS_DEF,
  localparam int TDW = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [TDW-1:0] in_tdata,   // a_real, a_imag, b_real, b_imag
  input  logic [1:0]     in_tuser,   // req_type
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [63:0]    out_tdata,  // res_real, res_imag
  output logic [1:0]     out_tuser   // status
);
  import cfpa_pkg::*;
  `include "complex_fixed_point_alu_macros.svh"

  localparam int W  = OPERAND_WIDTH;
  localparam int SW = cfpa_sw(OPERAND_WIDTH, FRACTION_BITS);
  localparam int CW = cfpa_cw(OPERAND_WIDTH, FRACTION_BITS);
  localparam int DW = 2 * OPERAND_WIDTH;
  localparam int DS = QBITS + 1;
  localparam int NS = DS + 3;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] load;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = out_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      load[k]  = rdy[k] && ((k == 0) ? in_tvalid : v_r[(k == 0) ? 0 : k - 1]);
      v_nxt[k] = rdy[k] ? ((k == 0) ? in_tvalid : v_r[(k == 0) ? 0 : k - 1]) : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[NS-1];

  // stage 0: products and sums
  logic signed [W-1:0] a_re, a_im, b_re, b_im;
  cfpa_op_t            op_in;

  assign a_re  = in_tdata[W-1:0];
  assign a_im  = in_tdata[2*W-1:W];
  assign b_re  = in_tdata[3*W-1:2*W];
  assign b_im  = in_tdata[4*W-1:3*W];
  assign op_in = cfpa_op_t'(in_tuser);

  logic signed [2*W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;
  logic signed [W:0]     s_re_r, s_im_r;
  cfpa_op_t              op0_r;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      p_rr_r <= a_re * b_re;
      p_ii_r <= a_im * b_im;
      p_ri_r <= a_re * b_im;
      p_ir_r <= a_im * b_re;
      p_bb_r <= b_re * b_re;
      p_cc_r <= b_im * b_im;
      s_re_r <= (op_in == OP_SUB) ? ((W+1)'(a_re) - (W+1)'(b_re)) : ((W+1)'(a_re) + (W+1)'(b_re));
      s_im_r <= (op_in == OP_SUB) ? ((W+1)'(a_im) - (W+1)'(b_im)) : ((W+1)'(a_im) + (W+1)'(b_im));
      op0_r  <= op_in;
    end
  end

  // stage 1: combine parts, squared magnitude
  logic signed [SW-1:0] num_nxt [2];
  logic [DW-1:0]        den_nxt;
  cfpa_ctl_t            ctl_nxt;
  logic signed [SW-1:0] num_r [2];
  logic [DW-1:0]        den_r;
  cfpa_ctl_t            ctl_r;

  always_comb begin
    den_nxt = DW'(p_bb_r) + DW'(p_cc_r);
    case (op0_r)
      OP_ADD, OP_SUB: begin
        num_nxt[0] = SW'(s_re_r) <<< FRACTION_BITS;
        num_nxt[1] = SW'(s_im_r) <<< FRACTION_BITS;
      end
      OP_MUL: begin
        num_nxt[0] = SW'(p_rr_r) - SW'(p_ii_r);
        num_nxt[1] = SW'(p_ri_r) + SW'(p_ir_r);
      end
      OP_DIV: begin
        num_nxt[0] = SW'(p_rr_r) + SW'(p_ii_r);
        num_nxt[1] = SW'(p_ir_r) - SW'(p_ri_r);
      end
      default: begin
        num_nxt[0] = '0;
        num_nxt[1] = '0;
      end
    endcase
    ctl_nxt.is_div = (op0_r == OP_DIV);
    ctl_nxt.dz     = (op0_r == OP_DIV) && (den_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  // stages 2 .. DS+1: divider
  cfpa_ctl_t     dctl;
  logic          dneg [2];
  logic [CW-1:0] dmag [2];
  logic          dovf [2];

  cfpa_div #(
    .OPERAND_WIDTH (OPERAND_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .load  (load[2 +: DS]),
    .ctl_i (ctl_r),
    .num_i (num_r),
    .den_i (den_r),
    .ctl_o (dctl),
    .neg_o (dneg),
    .mag_o (dmag),
    .ovf_o (dovf)
  );

  // last stage: clamp and status
  logic [31:0]   res_nxt [2];
  logic          sat     [2];
  logic [CW-1:0] negmag  [2];
  cfpa_status_t  st_nxt;
  logic [31:0]   res_re_r, res_im_r;
  cfpa_status_t  st_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      negmag[l] = CW'(0) - dmag[l];
      sat[l]    = dovf[l] || (dneg[l] ? (dmag[l] > CW'(LIM_NEG_MAG))
                                      : (dmag[l] > CW'(LIM_POS_MAG)));
      if (dctl.dz) begin
        res_nxt[l] = '0;
      end else if (sat[l]) begin
        res_nxt[l] = dneg[l] ? RES_MIN : RES_MAX;
      end else begin
        res_nxt[l] = dneg[l] ? negmag[l][31:0] : dmag[l][31:0];
      end
    end
    if (dctl.dz) begin
      st_nxt = ST_DZ;
    end else if (sat[0] || sat[1]) begin
      st_nxt = ST_SAT;
    end else begin
      st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (load[NS-1]) begin
      res_re_r <= res_nxt[0];
      res_im_r <= res_nxt[1];
      st_r     <= st_nxt;
    end
  end

  assign out_tdata = {res_im_r, res_re_r};
  assign out_tuser = st_r;

  `CFPA_ASSERT_NOW(a_dz_zero, out_tvalid && (out_tuser == ST_DZ), out_tdata == '0,
    "divide-by-zero result not zero")
  `CFPA_ASSERT_NOW(a_sat_limit, out_tvalid && (out_tuser == ST_SAT),
    (out_tdata[31:0] == RES_MAX) || (out_tdata[31:0] == RES_MIN) ||
    (out_tdata[63:32] == RES_MAX) || (out_tdata[63:32] == RES_MIN),
    "saturated status without a clamped part")
  `CFPA_ASSERT_NOW(a_full_stall, !in_tready, &v_r, "input stalled with a free stage")
  `CFPA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid,
    "pending result dropped")

endmodule
